// File: design/srrg_pkg.sv
package srrg_pkg;

  localparam int ADDR_W = 48;
  localparam int LEN_W = 31;
  localparam int CFG_AW = 5;
  localparam int CFG_DW = 64;
  localparam int REQ_CNT_W = 5;
  localparam int MAX_REQ = 32;

  localparam logic [ADDR_W-1:0] INT_MAX = 48'h0000_7FFF_FFFF;

  localparam logic [1:0] FUNC_LOAD_FILE = 2'd0;
  localparam logic [1:0] FUNC_LOAD_BUF  = 2'd1;
  localparam logic [1:0] FUNC_START     = 2'd2;

  localparam logic [1:0] REG_FILE_DISP   = 2'd0;
  localparam logic [1:0] REG_FILE_CONTIG = 2'd1;
  localparam logic [1:0] REG_FILE_COUNT  = 2'd2;

  typedef struct packed {
    logic [1:0]        func;
    logic [3:0]        entry_index;
    logic [ADDR_W-1:0] segment_offset;
    logic [ADDR_W-1:0] segment_length;
    logic [ADDR_W-1:0] view_start_offset;
    logic [ADDR_W-1:0] total_bytes;
    logic [4:0]        buffer_segment_count;
    logic              buffer_contiguous;
  } in_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] file_address;
    logic [ADDR_W-1:0] buffer_offset;
    logic [LEN_W-1:0]  request_length;
    logic              last_request;
    logic              table_overrun;
  } out_item_t;

  typedef struct packed {
    logic [ADDR_W-1:0] file_displacement;
    logic              file_view_contiguous;
    logic [4:0]        file_segment_count;
  } cfg_t;

  typedef struct packed {
    logic accept;
    logic latch;
    logic scan_step;
    logic buf_init;
    logic walk_step;
    logic load_step;
    logic rd_next_f;
    logic rd_next_b;
    logic emit_end;
    logic end_ovr;
  } dp_cmd_t;

  typedef struct packed {
    logic total_zero;
    logic file_contig;
    logic fcnt_zero;
    logic sc_found;
    logic sc_last;
    logic sc_nz;
    logic buf_contig;
    logic bcnt_zero;
    logic w_emit;
    logic w_last;
    logic n_full;
    logic f_adv;
    logic b_adv;
    logic f_brk;
    logic b_brk;
  } dp_sts_t;

endpackage

// File: design/srrg_ram.sv
module srrg_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: design/srrg_regs.sv
module srrg_regs import srrg_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t       cfg_r, cfg_nxt;
  logic       wr;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign wr      = psel && penable && pwrite;
  assign reg_idx = paddr[4:3];
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr) begin
      case (reg_idx)
        REG_FILE_DISP:   cfg_nxt.file_displacement = pwdata[ADDR_W-1:0];
        REG_FILE_CONTIG: cfg_nxt.file_view_contiguous = pwdata[0];
        REG_FILE_COUNT:  cfg_nxt.file_segment_count = pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_FILE_DISP:   prdata = {16'b0, cfg_r.file_displacement};
      REG_FILE_CONTIG: prdata = {63'b0, cfg_r.file_view_contiguous};
      REG_FILE_COUNT:  prdata = {59'b0, cfg_r.file_segment_count};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

// File: design/srrg_ctrl.sv
module srrg_ctrl import srrg_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [1:0] func,
  output logic       busy,
  output dp_cmd_t    cmd,
  input  dp_sts_t    sts
);

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SCAN  = 6'b000010,
    ST_BINIT = 6'b000100,
    ST_WALK  = 6'b001000,
    ST_LOAD  = 6'b010000,
    ST_OVR   = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign busy = (state_r != ST_IDLE);

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (func == FUNC_START) begin
            cmd.latch = 1'b1;
            if (sts.total_zero) begin
              cmd.emit_end = 1'b1;
            end else if (sts.file_contig) begin
              state_nxt = ST_BINIT;
            end else if (sts.fcnt_zero) begin
              cmd.emit_end = 1'b1;
            end else begin
              state_nxt = ST_SCAN;
            end
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        cmd.rd_next_f = 1'b1;
        if (sts.sc_found) begin
          state_nxt = ST_BINIT;
        end else if (sts.sc_last) begin
          // empty view gives a plain end beat, otherwise start is past the end
          cmd.emit_end = 1'b1;
          cmd.end_ovr  = sts.sc_nz;
          state_nxt    = ST_IDLE;
        end
      end
      ST_BINIT: begin
        if (!sts.buf_contig && sts.bcnt_zero) begin
          cmd.emit_end = 1'b1;
          cmd.end_ovr  = 1'b1;
          state_nxt    = ST_IDLE;
        end else begin
          cmd.buf_init = 1'b1;
          state_nxt    = ST_WALK;
        end
      end
      ST_WALK: begin
        cmd.walk_step = 1'b1;
        cmd.rd_next_f = 1'b1;
        cmd.rd_next_b = 1'b1;
        if (sts.w_emit && (sts.w_last || sts.n_full)) begin
          state_nxt = ST_IDLE;
        end else if (sts.f_brk || sts.b_brk) begin
          state_nxt = ST_OVR;
        end else if (sts.f_adv || sts.b_adv) begin
          state_nxt = ST_LOAD;
        end
      end
      ST_LOAD: begin
        cmd.load_step = 1'b1;
        state_nxt     = ST_WALK;
      end
      ST_OVR: begin
        cmd.emit_end = 1'b1;
        cmd.end_ovr  = 1'b1;
        state_nxt    = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

// File: design/srrg_dp.sv
module srrg_dp import srrg_pkg::*; #(
  parameter int FILE_SEGMENTS = 16,
  parameter int BUFFER_SEGMENTS = 16
) (
  input  logic      clk,
  input  logic      rst_n,
  input  in_item_t  in_item,
  input  cfg_t      cfg,
  input  dp_cmd_t   cmd,
  output dp_sts_t   sts,
  output logic      out_valid,
  output out_item_t out_item
);

  localparam int FAW = FILE_SEGMENTS > 1 ? $clog2(FILE_SEGMENTS) : 1;
  localparam int BAW = BUFFER_SEGMENTS > 1 ? $clog2(BUFFER_SEGMENTS) : 1;
  localparam int FCW = $clog2(FILE_SEGMENTS + 1);
  localparam int BCW = $clog2(BUFFER_SEGMENTS + 1);
  localparam int EW  = 2 * ADDR_W;

  // table memories: {offset, length} per entry
  logic           f_we, b_we;
  logic [FAW-1:0] f_waddr, f_raddr;
  logic [BAW-1:0] b_waddr, b_raddr;
  logic [EW-1:0]  ent_wdata, f_rdata, b_rdata;
  logic [ADDR_W-1:0] f_off, f_len, b_off, b_len;

  logic [FCW-1:0] f_r, f_nxt, fn_r, fn_nxt, f_inc, fcnt_clip;
  logic [BCW-1:0] b_r, b_nxt, bn_r, bn_nxt, b_inc, bcnt_clip;
  logic [ADDR_W-1:0] fa_r, fa_nxt, bo_r, bo_nxt;
  logic [ADDR_W-1:0] frd_r, frd_nxt, brd_r, brd_nxt;
  logic [ADDR_W-1:0] rem_r, rem_nxt, pos_r, pos_nxt;
  logic f_unb_r, f_unb_nxt, b_unb_r, b_unb_nxt;
  logic nz_r, nz_nxt, fld_r, fld_nxt, bld_r, bld_nxt;
  logic bcontig_r, bcontig_nxt;
  logic [REQ_CNT_W-1:0] n_r, n_nxt;
  logic out_valid_r, out_valid_nxt;
  out_item_t out_item_r, out_item_nxt;

  logic [ADDR_W-1:0] fb_min, cap, sz;
  logic fb_unb, found, w_emit, w_last, n_full, f_adv, b_adv;

  assign ent_wdata = {in_item.segment_offset, in_item.segment_length};
  assign f_we = cmd.accept && (in_item.func == FUNC_LOAD_FILE)
                && (32'(in_item.entry_index) < FILE_SEGMENTS);
  assign b_we = cmd.accept && (in_item.func == FUNC_LOAD_BUF)
                && (32'(in_item.entry_index) < BUFFER_SEGMENTS);
  assign f_waddr = FAW'(in_item.entry_index);
  assign b_waddr = BAW'(in_item.entry_index);

  assign f_inc   = f_r + FCW'(1);
  assign b_inc   = b_r + BCW'(1);
  // one read ahead: the next entry is fetched while the current one is used
  assign f_raddr = cmd.rd_next_f ? f_inc[FAW-1:0] : '0;
  assign b_raddr = cmd.rd_next_b ? b_inc[BAW-1:0] : '0;

  srrg_ram #(.WIDTH(EW), .DEPTH(FILE_SEGMENTS)) u_file_ram (
    .clk   (clk),
    .we    (f_we),
    .waddr (f_waddr),
    .wdata (ent_wdata),
    .raddr (f_raddr),
    .rdata (f_rdata)
  );

  srrg_ram #(.WIDTH(EW), .DEPTH(BUFFER_SEGMENTS)) u_buf_ram (
    .clk   (clk),
    .we    (b_we),
    .waddr (b_waddr),
    .wdata (ent_wdata),
    .raddr (b_raddr),
    .rdata (b_rdata)
  );

  assign f_off = f_rdata[EW-1:ADDR_W];
  assign f_len = f_rdata[ADDR_W-1:0];
  assign b_off = b_rdata[EW-1:ADDR_W];
  assign b_len = b_rdata[ADDR_W-1:0];

  assign fcnt_clip = (32'(cfg.file_segment_count) > FILE_SEGMENTS) ?
                     FCW'(FILE_SEGMENTS) : FCW'(cfg.file_segment_count);
  assign bcnt_clip = (32'(in_item.buffer_segment_count) > BUFFER_SEGMENTS) ?
                     BCW'(BUFFER_SEGMENTS) : BCW'(in_item.buffer_segment_count);

  // prefix search: pos_r is what is left of the start offset
  assign found = f_len > pos_r;

  // piece size: smallest of both segment remainders, run remainder and cap
  assign fb_unb = f_unb_r && b_unb_r;
  assign fb_min = f_unb_r ? brd_r :
                  b_unb_r ? frd_r :
                  (frd_r < brd_r) ? frd_r : brd_r;
  assign cap    = (rem_r < INT_MAX) ? rem_r : INT_MAX;
  assign sz     = (fb_unb || cap < fb_min) ? cap : fb_min;
  assign w_emit = (sz != '0);
  assign w_last = (sz == rem_r);
  assign n_full = (n_r == REQ_CNT_W'(MAX_REQ - 1));
  assign f_adv  = !f_unb_r && (frd_r == sz);
  assign b_adv  = !b_unb_r && (brd_r == sz);

  always_comb begin
    sts             = '0;
    sts.total_zero  = (in_item.total_bytes == '0);
    sts.file_contig = cfg.file_view_contiguous;
    sts.fcnt_zero   = (cfg.file_segment_count == '0);
    sts.sc_found    = found;
    sts.sc_last     = (f_inc == fn_r);
    sts.sc_nz       = nz_r || (f_len != '0);
    sts.buf_contig  = bcontig_r;
    sts.bcnt_zero   = (bn_r == '0);
    sts.w_emit      = w_emit;
    sts.w_last      = w_last;
    sts.n_full      = n_full;
    sts.f_adv       = f_adv;
    sts.b_adv       = b_adv;
    sts.f_brk       = f_adv && (f_inc >= fn_r);
    sts.b_brk       = b_adv && (b_inc >= bn_r);
  end

  always_comb begin
    f_nxt       = f_r;
    fn_nxt      = fn_r;
    b_nxt       = b_r;
    bn_nxt      = bn_r;
    fa_nxt      = fa_r;
    bo_nxt      = bo_r;
    frd_nxt     = frd_r;
    brd_nxt     = brd_r;
    rem_nxt     = rem_r;
    pos_nxt     = pos_r;
    f_unb_nxt   = f_unb_r;
    b_unb_nxt   = b_unb_r;
    nz_nxt      = nz_r;
    fld_nxt     = fld_r;
    bld_nxt     = bld_r;
    bcontig_nxt = bcontig_r;
    n_nxt       = n_r;

    if (cmd.latch) begin
      pos_nxt     = in_item.view_start_offset;
      rem_nxt     = in_item.total_bytes;
      fa_nxt      = cfg.file_displacement + in_item.view_start_offset;
      f_unb_nxt   = cfg.file_view_contiguous;
      f_nxt       = '0;
      b_nxt       = '0;
      fn_nxt      = fcnt_clip;
      bn_nxt      = bcnt_clip;
      bcontig_nxt = in_item.buffer_contiguous;
      nz_nxt      = 1'b0;
      n_nxt       = '0;
    end

    if (cmd.scan_step) begin
      if (found) begin
        frd_nxt = f_len - pos_r;
        fa_nxt  = cfg.file_displacement + f_off + pos_r;
      end else begin
        pos_nxt = pos_r - f_len;
        nz_nxt  = nz_r || (f_len != '0);
        f_nxt   = f_inc;
      end
    end

    if (cmd.buf_init) begin
      b_nxt = '0;
      if (bcontig_r) begin
        bo_nxt    = '0;
        brd_nxt   = '0;
        b_unb_nxt = 1'b1;
      end else begin
        bo_nxt    = b_off;
        brd_nxt   = b_len;
        b_unb_nxt = 1'b0;
      end
    end

    if (cmd.walk_step) begin
      frd_nxt = frd_r - sz;
      brd_nxt = brd_r - sz;
      fa_nxt  = fa_r + sz;
      bo_nxt  = bo_r + sz;
      fld_nxt = f_adv;
      bld_nxt = b_adv;
      if (w_emit) begin
        rem_nxt = rem_r - sz;
        n_nxt   = n_r + REQ_CNT_W'(1);
      end
    end

    if (cmd.load_step) begin
      if (fld_r) begin
        f_nxt   = f_inc;
        fa_nxt  = cfg.file_displacement + f_off;
        frd_nxt = f_len;
      end
      if (bld_r) begin
        b_nxt   = b_inc;
        bo_nxt  = b_off;
        brd_nxt = b_len;
      end
    end
  end

  always_comb begin
    out_valid_nxt = 1'b0;
    out_item_nxt  = out_item_r;
    if (cmd.emit_end) begin
      out_valid_nxt              = 1'b1;
      out_item_nxt               = '0;
      out_item_nxt.last_request  = 1'b1;
      out_item_nxt.table_overrun = cmd.end_ovr;
    end else if (cmd.walk_step && w_emit) begin
      out_valid_nxt               = 1'b1;
      out_item_nxt.file_address   = fa_r;
      out_item_nxt.buffer_offset  = bo_r;
      out_item_nxt.request_length = sz[LEN_W-1:0];
      // the beat that hits the request limit closes the run, as an overrun unless it ends the run
      out_item_nxt.last_request   = w_last || n_full;
      out_item_nxt.table_overrun  = !w_last && n_full;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    f_r        <= f_nxt;
    fn_r       <= fn_nxt;
    b_r        <= b_nxt;
    bn_r       <= bn_nxt;
    fa_r       <= fa_nxt;
    bo_r       <= bo_nxt;
    frd_r      <= frd_nxt;
    brd_r      <= brd_nxt;
    rem_r      <= rem_nxt;
    pos_r      <= pos_nxt;
    f_unb_r    <= f_unb_nxt;
    b_unb_r    <= b_unb_nxt;
    nz_r       <= nz_nxt;
    fld_r      <= fld_nxt;
    bld_r      <= bld_nxt;
    bcontig_r  <= bcontig_nxt;
    n_r        <= n_nxt;
    out_item_r <= out_item_nxt;
  end

endmodule

// File: design/strided_read_request_generator.sv
// channel   | ports                                   | beat taken when
// ----------+-----------------------------------------+----------------------------------
// input     | start, busy, in_item                    | start && !busy
// result    | out_valid, out_item                     | every cycle out_valid is high
// config    | psel, penable, pwrite, paddr, pwdata,   | psel && penable && pwrite
//           | prdata, pready                          | (registers at 8-byte steps)
//
// a load beat writes into the segment memories
// a run: a prefix search step per file entry walked, a buffer setup step, then
// a walk step per request or zero-length piece, a load step per segment change for
// the registered table read, and an overrun end beat
// zero-byte runs and views with no segments in use answer in the cycle after the
// start beat; reset needs no clearing pass; results are strobes that cannot stall
module strided_read_request_generator import srrg_pkg::*; #(
  parameter int FILE_SEGMENTS = 16,
  parameter int BUFFER_SEGMENTS = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  in_item_t          in_item,
  output logic              out_valid,
  output out_item_t         out_item,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready
);

  cfg_t    cfg;
  dp_cmd_t cmd;
  dp_sts_t sts;

  srrg_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  srrg_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_item.func),
    .busy  (busy),
    .cmd   (cmd),
    .sts   (sts)
  );

  srrg_dp #(
    .FILE_SEGMENTS   (FILE_SEGMENTS),
    .BUFFER_SEGMENTS (BUFFER_SEGMENTS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cfg       (cfg),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

// File: design/srrg_checker.sv
module srrg_checker import srrg_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_valid,
  input out_item_t out_item
);

  // the walk only begins on an accepted start beat
  a_busy_from_start: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(busy) |-> $past(start))
    else $error("busy rose without a start beat");

  // every result follows a start beat or a cycle of work
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ($past(busy) || $past(start)))
    else $error("result beat out of nowhere");

  // more results are coming, so the run is still busy
  a_mid_run_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.last_request) |-> busy)
    else $error("non-final result while idle");

  a_overrun_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.table_overrun) |-> out_item.last_request)
    else $error("overrun flag on a non-final result");

  a_zero_len_marker: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.request_length == '0) |->
      (out_item.last_request && out_item.file_address == '0 &&
       out_item.buffer_offset == '0))
    else $error("zero-length result that is not an end marker");

endmodule

bind strided_read_request_generator srrg_checker u_srrg_checker (.*);
